// ----- hw/rtl/ffua_pkg.sv -----
// ----------------------------------------------------------------------------
// ffua_pkg
// Shared types and constants of the first-fit unit allocator: operation
// codes, transfer payloads and the controller-to-datapath signal groups.
// ----------------------------------------------------------------------------
package ffua_pkg;

  // Default sizes of the owner table.
  localparam int unsigned UnitsDef  = 128;
  localparam int unsigned IdBitsDef = 8;

  // Fixed field widths of the transfers.
  localparam int unsigned CntW  = 8;
  localparam int unsigned PosW  = 8;
  localparam int unsigned HoleW = 7;
  localparam int unsigned OwnW  = 8;

  // Operation codes.
  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_COUNT = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  // Input transfer.
  typedef struct packed {
    op_e             operation;
    logic [OwnW-1:0] owner_id;
    logic [CntW-1:0] unit_count;
  } in_t;

  // Result transfer.
  typedef struct packed {
    logic             status;
    logic [PosW-1:0]  position;
    logic [HoleW-1:0] hole_count;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // latch a new item and reset the scan state
    logic scan_en;    // read the table and evaluate entries
    logic fill_load;  // point the address at the found run
    logic fill_en;    // write the owner into the found run
    logic clear_en;   // write a free entry at the sweep address
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_e  op;         // operation of the current item
    logic scan_done;  // scan has finished, by a hit or at the last unit
    logic hit;        // allocate found a fitting run
    logic need_nz;    // allocate asked for at least one unit
    logic fill_last;  // last unit of the run is being written
    logic addr_last;  // sweep address is at the last unit
  } sts_t;

endpackage

// ----- hw/rtl/first_fit_unit_allocator_core.sv -----
// ----------------------------------------------------------------------------
// first_fit_unit_allocator_core
// First-fit allocator over a table of UNITS units, each free or held by an
// owner: allocate, free by owner, count free holes and clear all.
//
//   channel | ports                    | transfer when
//   --------+--------------------------+-------------------------------
//   command | start_i, item_i, busy_o  | start_i high while busy_o low
//   result  | done_o, result_o         | done_o high, one cycle
//
// The table is one memory with one read and one write port; every operation
// walks it one unit per cycle. After reset the block sweeps the table to all
// free with busy_o high. The result is shown for one cycle and cannot be held
// off.
// ----------------------------------------------------------------------------
module first_fit_unit_allocator_core
  import ffua_pkg::*;
#(
  parameter int unsigned UNITS   = UnitsDef,
  parameter int unsigned ID_BITS = IdBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  in_t  item_i,
  output logic busy_o,
  output logic done_o,
  output out_t result_o
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  ffua_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .op_i    (item_i.operation),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  // Table and scan datapath.
  ffua_dpath #(
    .UNITS   (UNITS),
    .ID_BITS (ID_BITS)
  ) u_dpath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .item_i   (item_i),
    .sts_o    (sts),
    .result_o (result_o)
  );

endmodule

// ----- hw/rtl/ffua_ctrl.sv -----
// ----------------------------------------------------------------------------
// ffua_ctrl
// Sequencer of the allocator: runs the clearing sweep after reset and
// steps each operation through its scan, fill or clear phase.
// ----------------------------------------------------------------------------
module ffua_ctrl
  import ffua_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  op_e  op_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic busy_o,
  output logic done_o
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_FILL,
    S_CLEAR,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   busy_q, done_q;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_INIT: begin
        cmd_o.clear_en = 1'b1;
        if (sts_i.addr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = (op_i == OP_CLEAR) ? S_CLEAR : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_en = 1'b1;
        if (sts_i.scan_done) begin
          if (sts_i.op == OP_ALLOC && sts_i.hit && sts_i.need_nz) begin
            cmd_o.fill_load = 1'b1;
            state_d         = S_FILL;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_FILL: begin
        cmd_o.fill_en = 1'b1;
        if (sts_i.fill_last) state_d = S_DONE;
      end
      S_CLEAR: begin
        cmd_o.clear_en = 1'b1;
        if (sts_i.addr_last) state_d = S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and registered handshake outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      busy_q  <= 1'b1;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != S_IDLE);
      done_q  <= (state_d == S_DONE);
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule

// ----- hw/rtl/ffua_dpath.sv -----
// ----------------------------------------------------------------------------
// ffua_dpath
// Owner table memory with its scan address, first-fit run tracking, hole
// counter and owner match, driven by commands from the controller.
// ----------------------------------------------------------------------------
module ffua_dpath
  import ffua_pkg::*;
#(
  parameter int unsigned UNITS   = UnitsDef,
  parameter int unsigned ID_BITS = IdBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t cmd_i,
  input  in_t  item_i,
  output sts_t sts_o,
  output out_t result_o
);

  localparam int unsigned AW = (UNITS > 1) ? $clog2(UNITS) : 1;
  localparam int unsigned EW = ID_BITS + 1;
  localparam int unsigned SW = (AW + 1 > PosW) ? AW + 1 : PosW;
  localparam logic [AW-1:0] LastAddr = AW'(UNITS - 1);

  // Table entry: used bit on top, owner below.
  logic [EW-1:0] mem_q [UNITS];

  // Latched item.
  op_e               op_q;
  logic [ID_BITS-1:0] owner_q;
  logic [CntW-1:0]   need_q;

  // Scan and fill state.
  logic [AW-1:0]   addr_q, addr_d;
  logic            issue_done_q, issue_done_d;
  logic            rd_vld_q, rd_vld_d;
  logic [AW-1:0]   rd_idx_q;
  logic [EW-1:0]   rd_data_q;
  logic            hit_q, hit_d;
  logic            proc_done_q, proc_done_d;
  logic            found_q, found_d;
  logic            prev_free_q, prev_free_d;
  logic [CntW-1:0] run_q, run_d;
  logic [AW-1:0]   start_q, start_d;
  logic [HoleW-1:0] holes_q, holes_d;
  logic [CntW-1:0] fill_cnt_q, fill_cnt_d;

  logic          rd_en;
  logic          proc;
  logic          unit_free;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;
  logic [SW-1:0] pos_w;

  assign rd_en     = cmd_i.scan_en && !issue_done_q;
  assign proc      = cmd_i.scan_en && rd_vld_q && !hit_q && !proc_done_q;
  assign unit_free = !rd_data_q[ID_BITS];

  // Scan, run tracking and fill sequencing.
  always_comb begin
    addr_d       = addr_q;
    issue_done_d = issue_done_q;
    rd_vld_d     = 1'b0;
    hit_d        = hit_q;
    proc_done_d  = proc_done_q;
    found_d      = found_q;
    prev_free_d  = prev_free_q;
    run_d        = run_q;
    start_d      = start_q;
    holes_d      = holes_q;
    fill_cnt_d   = fill_cnt_q;
    wr_en        = 1'b0;
    wr_addr      = addr_q;
    wr_data      = '0;

    if (cmd_i.load) begin
      addr_d       = '0;
      issue_done_d = 1'b0;
      hit_d        = 1'b0;
      proc_done_d  = 1'b0;
      found_d      = 1'b0;
      prev_free_d  = 1'b0;
      run_d        = '0;
      holes_d      = '0;
    end

    // Issue one read per cycle until the last unit.
    if (rd_en) begin
      rd_vld_d = 1'b1;
      addr_d   = addr_q + AW'(1);
      if (addr_q == LastAddr) issue_done_d = 1'b1;
    end

    // Evaluate the entry that came back from the table.
    if (proc) begin
      if (rd_idx_q == LastAddr) proc_done_d = 1'b1;
      unique case (op_q)
        OP_ALLOC: begin
          if (unit_free) begin
            if (need_q == '0) begin
              hit_d   = 1'b1;
              start_d = rd_idx_q;
            end else begin
              if (run_q == '0) start_d = rd_idx_q;
              run_d = run_q + CntW'(1);
              if (run_q + CntW'(1) == need_q) hit_d = 1'b1;
            end
          end else begin
            run_d = '0;
          end
        end
        OP_FREE: begin
          if (!unit_free && rd_data_q[ID_BITS-1:0] == owner_q) begin
            wr_en   = 1'b1;
            wr_addr = rd_idx_q;
            wr_data = '0;
            found_d = 1'b1;
          end
        end
        OP_COUNT: begin
          if (unit_free && !prev_free_q) holes_d = holes_q + HoleW'(1);
          prev_free_d = unit_free;
        end
        OP_CLEAR: begin
        end
        default: begin
        end
      endcase
    end

    // Jump to the found run before writing it.
    if (cmd_i.fill_load) begin
      addr_d     = start_q;
      fill_cnt_d = '0;
    end

    // Mark the run with the owner.
    if (cmd_i.fill_en) begin
      wr_en      = 1'b1;
      wr_addr    = addr_q;
      wr_data    = {1'b1, owner_q};
      addr_d     = addr_q + AW'(1);
      fill_cnt_d = fill_cnt_q + CntW'(1);
    end

    // Sweep free entries through the whole table.
    if (cmd_i.clear_en) begin
      wr_en   = 1'b1;
      wr_addr = addr_q;
      wr_data = '0;
      addr_d  = addr_q + AW'(1);
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q       <= '0;
      issue_done_q <= 1'b0;
      rd_vld_q     <= 1'b0;
      hit_q        <= 1'b0;
      proc_done_q  <= 1'b0;
      found_q      <= 1'b0;
      prev_free_q  <= 1'b0;
      run_q        <= '0;
      holes_q      <= '0;
      fill_cnt_q   <= '0;
    end else begin
      addr_q       <= addr_d;
      issue_done_q <= issue_done_d;
      rd_vld_q     <= rd_vld_d;
      hit_q        <= hit_d;
      proc_done_q  <= proc_done_d;
      found_q      <= found_d;
      prev_free_q  <= prev_free_d;
      run_q        <= run_d;
      holes_q      <= holes_d;
      fill_cnt_q   <= fill_cnt_d;
    end
  end

  // Item and run start registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= item_i.operation;
      owner_q <= ID_BITS'(item_i.owner_id);
      need_q  <= item_i.unit_count;
    end
    start_q <= start_d;
    if (rd_en) rd_idx_q <= addr_q;
  end

  // Table write port.
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
  end

  // Table read port with registered data.
  always_ff @(posedge clk_i) begin
    if (rd_en) rd_data_q <= mem_q[addr_q];
  end

  // Status toward the controller.
  always_comb begin
    sts_o.op        = op_q;
    sts_o.scan_done = hit_q || proc_done_q;
    sts_o.hit       = hit_q;
    sts_o.need_nz   = (need_q != '0);
    sts_o.fill_last = (fill_cnt_q == need_q - CntW'(1));
    sts_o.addr_last = (addr_q == LastAddr);
  end

  // Result fields, stable once the operation has finished.
  assign pos_w = SW'(start_q) + SW'(1);

  always_comb begin
    result_o = '0;
    unique case (op_q)
      OP_ALLOC: begin
        result_o.status   = !hit_q;
        result_o.position = hit_q ? pos_w[PosW-1:0] : '0;
      end
      OP_FREE: begin
        result_o.status = !found_q;
      end
      OP_COUNT: begin
        result_o.hole_count = holes_q;
      end
      OP_CLEAR: begin
        result_o.status = 1'b0;
      end
      default: begin
        result_o = '0;
      end
    endcase
  end

endmodule

// ----- dv/first_fit_unit_allocator_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_unit_allocator_core_test
// Self-checking testbench for the first-fit unit allocator. A behavioral copy
// of the owner table predicts every result at the command transfer; a
// monitor compares each result transfer field by field in order. Directed
// corner cases, a checkerboard fill and random traffic with and without gaps
// are run in turn.
// ----------------------------------------------------------------------------
module first_fit_unit_allocator_core_test;
  import ffua_pkg::*;

  localparam int unsigned Units      = UnitsDef;
  localparam int unsigned CycleLimit = 3_000_000;
  localparam int unsigned MaxReports = 10;

  logic clk_i;
  logic rst_ni;
  logic start_i;
  in_t  item_i;
  logic busy_o;
  logic done_o;
  out_t result_o;

  // Behavioral copy of the owner table.
  bit          unit_held   [Units];
  logic [7:0]  unit_holder [Units];

  // Results predicted at command transfer, oldest first.
  out_t        pending_results[$];
  out_t        oldest_result;
  int unsigned mismatch_cnt;
  int unsigned cycle_cnt;
  bit          gaps_on;
  logic [7:0]  owner_pool [6];

  first_fit_unit_allocator_core u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .item_i  (item_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .result_o(result_o)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Applies one command to the table copy and returns the result it causes.
  function automatic out_t apply_allocator_op(in_t cmd);
    out_t        res;
    int unsigned need;
    int unsigned run;
    bit          prev_free;
    res  = '0;
    need = cmd.unit_count;
    case (cmd.operation)
      OP_ALLOC: begin
        // First fit: lowest free start with enough free units behind it.
        res.status = 1'b1;
        for (int unsigned i = 0; i < Units && res.status; i++) begin
          if (!unit_held[i]) begin
            run = 0;
            while (run < need && i + run < Units && !unit_held[i + run]) run++;
            if (run == need) begin
              for (int unsigned k = 0; k < need; k++) begin
                unit_held[i + k]   = 1'b1;
                unit_holder[i + k] = cmd.owner_id;
              end
              res.status   = 1'b0;
              res.position = PosW'(i + 1);
            end
          end
        end
      end
      OP_FREE: begin
        res.status = 1'b1;
        for (int unsigned i = 0; i < Units; i++) begin
          if (unit_held[i] && unit_holder[i] == cmd.owner_id) begin
            unit_held[i]   = 1'b0;
            unit_holder[i] = '0;
            res.status     = 1'b0;
          end
        end
      end
      OP_COUNT: begin
        prev_free = 1'b0;
        for (int unsigned i = 0; i < Units; i++) begin
          if (!unit_held[i] && !prev_free) res.hole_count = res.hole_count + 1'b1;
          prev_free = !unit_held[i];
        end
      end
      default: begin
        for (int unsigned i = 0; i < Units; i++) begin
          unit_held[i]   = 1'b0;
          unit_holder[i] = '0;
        end
      end
    endcase
    return res;
  endfunction

  // Sends one command, with an optional random gap before it.
  task automatic send_item(in_t cmd);
    if (gaps_on && $urandom_range(0, 2) == 0) begin
      @(negedge clk_i);
      start_i = 1'b0;
      // Sometimes let the block go idle first so the gap lands after busy drops.
      if ($urandom_range(0, 1)) while (busy_o) @(negedge clk_i);
      repeat ($urandom_range(0, 12)) @(negedge clk_i);
    end
    @(negedge clk_i);
    start_i = 1'b1;
    item_i  = cmd;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    pending_results.push_back(apply_allocator_op(cmd));
  endtask

  task automatic send_op(op_e op, logic [7:0] owner, logic [7:0] count);
    in_t cmd;
    cmd.operation  = op;
    cmd.owner_id   = owner;
    cmd.unit_count = count;
    send_item(cmd);
  endtask

  // Holds start low until every predicted result has arrived.
  task automatic wait_results_drained();
    @(negedge clk_i);
    start_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Random command, biased toward a small set of owners so frees hit.
  function automatic in_t random_item();
    in_t         cmd;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    cmd.operation = (pick < 50) ? OP_ALLOC : (pick < 78) ? OP_FREE :
                    (pick < 97) ? OP_COUNT : OP_CLEAR;
    cmd.owner_id  = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) :
                    owner_pool[$urandom_range(0, 5)];
    pick = $urandom_range(0, 99);
    if (pick < 60)      cmd.unit_count = 8'($urandom_range(0, 8));
    else if (pick < 85) cmd.unit_count = 8'($urandom_range(9, 40));
    else if (pick < 95) cmd.unit_count = 8'($urandom_range(41, 128));
    else                cmd.unit_count = 8'($urandom_range(129, 255));
    return cmd;
  endfunction

  // Corner cases: empty and full table, zero and oversize counts, frees of
  // owners that hold nothing, refill of a hole and clear.
  task automatic test_edge_cases();
    gaps_on = 1'b1;
    send_op(OP_COUNT, 8'h00, 8'd0);
    send_op(OP_ALLOC, 8'h00, 8'd0);
    send_op(OP_ALLOC, 8'hFF, 8'd128);
    send_op(OP_ALLOC, 8'h01, 8'd1);
    send_op(OP_ALLOC, 8'h01, 8'd0);
    send_op(OP_COUNT, 8'h00, 8'd0);
    send_op(OP_FREE,  8'h03, 8'd0);
    send_op(OP_FREE,  8'hFF, 8'd0);
    send_op(OP_ALLOC, 8'h07, 8'd129);
    send_op(OP_ALLOC, 8'h07, 8'd255);
    send_op(OP_ALLOC, 8'h00, 8'd5);
    send_op(OP_ALLOC, 8'h80, 8'd3);
    send_op(OP_ALLOC, 8'h7F, 8'd120);
    send_op(OP_FREE,  8'h80, 8'hFF);
    send_op(OP_COUNT, 8'hFF, 8'hFF);
    send_op(OP_ALLOC, 8'h01, 8'd4);
    send_op(OP_ALLOC, 8'h55, 8'd3);
    send_op(OP_FREE,  8'h00, 8'd0);
    send_op(OP_COUNT, 8'h00, 8'd0);
    send_op(OP_FREE,  8'h00, 8'd0);
    send_op(OP_CLEAR, 8'hFF, 8'hFF);
    send_op(OP_COUNT, 8'h00, 8'd0);
    send_op(OP_ALLOC, 8'hAA, 8'd128);
    send_op(OP_CLEAR, 8'h00, 8'd0);
    send_op(OP_COUNT, 8'h00, 8'd0);
  endtask

  // Single units with alternating owners, then one owner freed: the most
  // holes the table can have.
  task automatic test_checkerboard();
    logic [7:0] even_owner;
    logic [7:0] odd_owner;
    even_owner = 8'($urandom_range(0, 127));
    odd_owner  = even_owner | 8'h80;
    gaps_on    = 1'b1;
    for (int unsigned i = 0; i < Units; i++) begin
      send_op(OP_ALLOC, (i % 2 == 0) ? even_owner : odd_owner, 8'd1);
    end
    send_op(OP_ALLOC, even_owner, 8'd1);
    send_op(OP_COUNT, 8'h00, 8'd0);
    send_op(OP_FREE,  odd_owner, 8'd0);
    send_op(OP_COUNT, 8'h00, 8'd0);
    send_op(OP_ALLOC, even_owner, 8'd2);
    send_op(OP_ALLOC, odd_owner, 8'd0);
    send_op(OP_CLEAR, 8'h00, 8'd0);
  endtask

  // Random traffic; gaps switch on and off in stretches, with an occasional
  // full drain of the result stream.
  task automatic test_random_mix(int unsigned n_items);
    foreach (owner_pool[i]) owner_pool[i] = 8'($urandom_range(0, 255));
    for (int unsigned n = 0; n < n_items; n++) begin
      if (n % 40 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 49) == 0) wait_results_drained();
      send_item(random_item());
    end
  endtask

  // The sender stops after short bursts until all results are back.
  task automatic test_drain_pause();
    gaps_on = 1'b0;
    for (int unsigned round = 0; round < 20; round++) begin
      repeat ($urandom_range(1, 3)) send_item(random_item());
      wait_results_drained();
    end
  endtask

  // Closing stretch with commands offered on every cycle.
  task automatic test_back_to_back(int unsigned n_items);
    gaps_on = 1'b0;
    repeat (n_items) send_item(random_item());
  endtask

  task automatic note_mismatch(string what, int unsigned exp_val, int unsigned act_val);
    if (mismatch_cnt < MaxReports) begin
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what,
               exp_val, act_val);
    end
    mismatch_cnt++;
  endtask

  // Result monitor: every result transfer is checked against the oldest
  // prediction.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected result, status", 0, result_o.status);
      end else begin
        oldest_result = pending_results.pop_front();
        if (result_o.status !== oldest_result.status)
          note_mismatch("status", oldest_result.status, result_o.status);
        if (result_o.position !== oldest_result.position)
          note_mismatch("position", oldest_result.position, result_o.position);
        if (result_o.hole_count !== oldest_result.hole_count)
          note_mismatch("hole_count", oldest_result.hole_count, result_o.hole_count);
      end
    end
  end

  // Watchdog on total run length.
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Some tests failed");
    $finish;
  end

  // Test sequence.
  initial begin
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    item_i       = '0;
    mismatch_cnt = 0;
    gaps_on      = 1'b0;
    foreach (unit_held[i]) begin
      unit_held[i]   = 1'b0;
      unit_holder[i] = '0;
    end
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_edge_cases();
    test_checkerboard();
    test_random_mix(1150);
    test_drain_pause();
    test_back_to_back(330);

    wait_results_drained();
    repeat (Units + 40) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
